### sv/pcmfi_pkg.sv
// shared types, register indexes and constants for the pcm linear fade-in block
package pcmfi_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 16;
    localparam int GAIN_W             = 18;
    localparam int SAMPLE_W           = 16;
    localparam int FRAMES_W           = 16;
    localparam int STEP_W             = 17;
    localparam int CFG_INDEX_W        = 2;
    localparam int CFG_DATA_W         = 17;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SAMPLE_16BIT = 2'd0,
        REG_STEREO       = 2'd1,
        REG_FADE_LENGTH  = 2'd2,
        REG_FADE_STEP    = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_FRAME   = 1'b0,
        OP_RESTART = 1'b1
    } op_t;

    typedef struct packed {
        logic                sample_16bit;
        logic                stereo;
        logic [FRAMES_W-1:0] fade_length;
        logic [STEP_W-1:0]   fade_step;
    } cfg_t;

    // ramp update request from the pipeline
    typedef struct packed {
        logic advance;
        logic restart;
    } ramp_ctl_t;

    localparam cfg_t CFG_RESET = '{
        sample_16bit: 1'b1,
        stereo:       1'b1,
        fade_length:  '0,
        fade_step:    STEP_W'(1)
    };

endpackage

### sv/pcmfi_cfg_regs.sv
// configuration register file for the fade-in block
module pcmfi_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pcmfi_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pcmfi_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pcmfi_pkg::cfg_t                    cfg
);

    pcmfi_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= pcmfi_pkg::CFG_RESET;
        end else if (cfg_valid) begin
            case (pcmfi_pkg::cfg_reg_t'(cfg_index))
                pcmfi_pkg::REG_SAMPLE_16BIT: cfg_reg.sample_16bit <= cfg_data[0];
                pcmfi_pkg::REG_STEREO:       cfg_reg.stereo       <= cfg_data[0];
                pcmfi_pkg::REG_FADE_LENGTH: begin
                    cfg_reg.fade_length <= cfg_data[pcmfi_pkg::FRAMES_W-1:0];
                end
                pcmfi_pkg::REG_FADE_STEP: begin
                    cfg_reg.fade_step <= cfg_data[pcmfi_pkg::STEP_W-1:0];
                end
                default: ;
            endcase
        end
    end

endmodule

### sv/pcmfi_ramp.sv
// gain ramp and remaining-frame counter
module pcmfi_ramp #(
    parameter int GAIN_FRAC_BITS = pcmfi_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pcmfi_pkg::ramp_ctl_t      ctl,
    input  pcmfi_pkg::cfg_t           cfg,
    output logic                      active,
    output logic [GAIN_FRAC_BITS-1:0] gain
);

    logic [pcmfi_pkg::GAIN_W-1:0]   gain_reg, gain_next, gain_sum;
    logic [pcmfi_pkg::FRAMES_W-1:0] frames_reg, frames_next;
    logic                           gain_full;

    assign active = (frames_reg != '0);
    // while active the gain is always below one, so the low bits carry it all
    assign gain   = gain_reg[GAIN_FRAC_BITS-1:0];

    assign gain_sum  = gain_reg + pcmfi_pkg::GAIN_W'(cfg.fade_step);
    assign gain_full = |gain_sum[pcmfi_pkg::GAIN_W-1:GAIN_FRAC_BITS];

    always_comb begin
        gain_next   = gain_reg;
        frames_next = frames_reg;
        if (ctl.advance) begin
            if (ctl.restart) begin
                gain_next   = '0;
                frames_next = cfg.fade_length;
            end else if (active) begin
                gain_next   = gain_sum;
                frames_next = gain_full ? '0 : frames_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= '0;
            frames_reg <= '0;
        end else begin
            gain_reg   <= gain_next;
            frames_reg <= frames_next;
        end
    end

endmodule

### sv/pcmfi_chan.sv
// one channel of the fade: recenter, multiply by the gain, shift back
module pcmfi_chan #(
    parameter int GAIN_FRAC_BITS = pcmfi_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic signed [pcmfi_pkg::SAMPLE_W-1:0] sample,
    input  logic        [GAIN_FRAC_BITS-1:0]      gain,
    input  logic                                  sample_16bit,
    output logic signed [pcmfi_pkg::SAMPLE_W-1:0] faded
);

    localparam int PROD_W = pcmfi_pkg::SAMPLE_W + GAIN_FRAC_BITS + 1;

    logic signed [pcmfi_pkg::SAMPLE_W-1:0] centered;
    logic signed [GAIN_FRAC_BITS:0]        gain_s;
    logic signed [PROD_W-1:0]              prod;

    // unsigned byte minus 128 is the byte with its top bit flipped
    assign centered = sample_16bit ? sample : {~sample[7], sample[6:0], 8'h00};
    assign gain_s   = {1'b0, gain};
    assign prod     = centered * gain_s;

    always_comb begin
        if (sample_16bit) begin
            faded = prod[GAIN_FRAC_BITS +: pcmfi_pkg::SAMPLE_W];
        end else begin
            // byte result lies in -128..127, adding 128 flips bit 7 back
            faded = {8'h00, ~prod[GAIN_FRAC_BITS + 15], prod[GAIN_FRAC_BITS + 8 +: 7]};
        end
    end

endmodule

### sv/pcm_linear_fade_in.sv
// top level of the pcm linear fade-in block
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | s_op, s_left_in, s_right_in
//  m_      | out       | m_valid / m_ready    | m_left_out, m_right_out, m_fade_active
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one frame per cycle sustained while m_ready stays high; an accepted beat passes the
// input register, then one multiply per channel, on its way to the result register.
// ramp state advances as a frame leaves the input register for the result register.
// reset is synchronous and active low; it clears the ramp and loads register defaults.
// a stalled result holds both stages; the input side keeps taking beats until
// the input register is also full. cfg_ready is always high.
module pcm_linear_fade_in #(
    parameter int GAIN_FRAC_BITS = pcmfi_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_op,
    input  logic signed [pcmfi_pkg::SAMPLE_W-1:0] s_left_in,
    input  logic signed [pcmfi_pkg::SAMPLE_W-1:0] s_right_in,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [pcmfi_pkg::SAMPLE_W-1:0] m_left_out,
    output logic signed [pcmfi_pkg::SAMPLE_W-1:0] m_right_out,
    output logic                                  m_fade_active,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pcmfi_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pcmfi_pkg::CFG_DATA_W-1:0]      cfg_data
);

    pcmfi_pkg::cfg_t      cfg;
    pcmfi_pkg::ramp_ctl_t ramp_ctl;

    logic                                  in_valid_reg;
    logic                                  in_op_reg;
    logic signed [pcmfi_pkg::SAMPLE_W-1:0] in_left_reg, in_right_reg;
    logic                                  out_valid_reg;
    logic signed [pcmfi_pkg::SAMPLE_W-1:0] out_left_reg, out_right_reg;
    logic                                  out_active_reg;

    logic signed [pcmfi_pkg::SAMPLE_W-1:0] left_next, right_next;
    logic signed [pcmfi_pkg::SAMPLE_W-1:0] left_faded, right_faded;
    logic                                  active_next;
    logic                                  ramp_active;
    logic [GAIN_FRAC_BITS-1:0]             gain;
    logic                                  out_free, move;

    pcmfi_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign move     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign ramp_ctl.advance = move;
    assign ramp_ctl.restart = (in_op_reg == pcmfi_pkg::OP_RESTART);

    pcmfi_ramp #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_ramp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ramp_ctl),
        .cfg     (cfg),
        .active  (ramp_active),
        .gain    (gain)
    );

    pcmfi_chan #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_left (
        .sample       (in_left_reg),
        .gain         (gain),
        .sample_16bit (cfg.sample_16bit),
        .faded        (left_faded)
    );

    pcmfi_chan #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_right (
        .sample       (in_right_reg),
        .gain         (gain),
        .sample_16bit (cfg.sample_16bit),
        .faded        (right_faded)
    );

    always_comb begin
        if (in_op_reg == pcmfi_pkg::OP_RESTART) begin
            left_next   = '0;
            right_next  = '0;
            active_next = 1'b0;
        end else if (!ramp_active) begin
            left_next   = in_left_reg;
            right_next  = in_right_reg;
            active_next = 1'b0;
        end else begin
            left_next   = left_faded;
            right_next  = cfg.stereo ? right_faded : in_right_reg;
            active_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg    <= s_op;
            in_left_reg  <= s_left_in;
            in_right_reg <= s_right_in;
        end
        if (move) begin
            out_left_reg   <= left_next;
            out_right_reg  <= right_next;
            out_active_reg <= active_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_left_out    = out_left_reg;
    assign m_right_out   = out_right_reg;
    assign m_fade_active = out_active_reg;

endmodule

### sv/pcmfi_checker.sv
// port-level checks for the fade-in block, bound to the top level
module pcmfi_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [pcmfi_pkg::SAMPLE_W-1:0] m_left_out,
    input logic signed [pcmfi_pkg::SAMPLE_W-1:0] m_right_out,
    input logic                                  m_fade_active,
    input logic                                  cfg_ready
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_out)
            && $stable(m_right_out) && $stable(m_fade_active))
        else $error("result beat changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // with the result register empty the input side must take a beat
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // a beat taken while the result register is empty passes the input register, then shows on the output
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> ##1 m_valid)
        else $error("accepted beat did not reach the result register");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind pcm_linear_fade_in pcmfi_checker u_pcmfi_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_left_out    (m_left_out),
    .m_right_out   (m_right_out),
    .m_fade_active (m_fade_active),
    .cfg_ready     (cfg_ready)
);

### test/testbench.sv
// testbench for the pcm linear fade-in block: predicted frames checked against each result beat
module testbench;

    localparam int FRAC_BITS      = pcmfi_pkg::GAIN_FRAC_BITS_DEF;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_PRINTED    = 40;

    typedef struct {
        logic [pcmfi_pkg::SAMPLE_W-1:0] left;
        logic [pcmfi_pkg::SAMPLE_W-1:0] right;
        logic                           active;
    } faded_frame_t;

    logic                                  aclk          = 1'b0;
    logic                                  aresetn       = 1'b0;
    logic                                  s_valid       = 1'b0;
    logic                                  s_ready;
    logic                                  s_op          = pcmfi_pkg::OP_FRAME;
    logic signed [pcmfi_pkg::SAMPLE_W-1:0] s_left_in     = '0;
    logic signed [pcmfi_pkg::SAMPLE_W-1:0] s_right_in    = '0;
    logic                                  m_valid;
    logic                                  m_ready       = 1'b0;
    logic signed [pcmfi_pkg::SAMPLE_W-1:0] m_left_out;
    logic signed [pcmfi_pkg::SAMPLE_W-1:0] m_right_out;
    logic                                  m_fade_active;
    logic                                  cfg_valid     = 1'b0;
    logic                                  cfg_ready;
    logic [pcmfi_pkg::CFG_INDEX_W-1:0]     cfg_index     = pcmfi_pkg::REG_SAMPLE_16BIT;
    logic [pcmfi_pkg::CFG_DATA_W-1:0]      cfg_data      = '0;

    // predictor state: register copy and ramp
    pcmfi_pkg::cfg_t                shadow_cfg;
    logic [pcmfi_pkg::GAIN_W-1:0]   ramp_gain;
    logic [pcmfi_pkg::FRAMES_W-1:0] ramp_frames;
    faded_frame_t                   expected_frames[$];

    int mismatch_count = 0;
    bit tx_steady      = 1'b0;
    bit rx_steady      = 1'b0;
    bit rx_hold_req    = 1'b0;

    pcm_linear_fade_in u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_left_in     (s_left_in),
        .s_right_in    (s_right_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_out    (m_left_out),
        .m_right_out   (m_right_out),
        .m_fade_active (m_fade_active),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // gain applied to one sample in the current sample format
    function automatic logic [pcmfi_pkg::SAMPLE_W-1:0] apply_gain(
        logic [pcmfi_pkg::SAMPLE_W-1:0] raw);
        longint s;
        longint p;
        if (shadow_cfg.sample_16bit) begin
            s = longint'($signed(raw));
            p = (s * longint'(ramp_gain)) >>> FRAC_BITS;
        end else begin
            s = (longint'(raw[7:0]) - 128) * 256;
            p = ((s * longint'(ramp_gain)) >>> FRAC_BITS) >>> 8;
            p = p + 128;
        end
        return p[pcmfi_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic void predict_faded_frame(pcmfi_pkg::op_t op,
                                                logic [pcmfi_pkg::SAMPLE_W-1:0] l,
                                                logic [pcmfi_pkg::SAMPLE_W-1:0] r);
        faded_frame_t e;
        if (op == pcmfi_pkg::OP_RESTART) begin
            ramp_gain   = '0;
            ramp_frames = shadow_cfg.fade_length;
            e = '{left: '0, right: '0, active: 1'b0};
        end else if (ramp_frames == 0) begin
            e = '{left: l, right: r, active: 1'b0};
        end else begin
            e.left   = apply_gain(l);
            e.right  = shadow_cfg.stereo ? apply_gain(r) : r;
            e.active = 1'b1;
            ramp_gain   = ramp_gain + pcmfi_pkg::GAIN_W'(shadow_cfg.fade_step);
            ramp_frames = ramp_frames - 1'b1;
            if (ramp_gain >= (pcmfi_pkg::GAIN_W'(1) << FRAC_BITS)) ramp_frames = '0;
        end
        expected_frames.push_back(e);
    endfunction

    task automatic report_mismatch(string what, logic [pcmfi_pkg::SAMPLE_W-1:0] got,
                                   logic [pcmfi_pkg::SAMPLE_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch %s at %0t: got %h expected %h", what, $realtime, got, want);
    endtask

    // result beats are taken at the falling edge before the accepting rising edge
    always @(negedge aclk) begin
        faded_frame_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                report_mismatch("unexpected beat", m_left_out, '0);
            end else begin
                e = expected_frames.pop_front();
                if (m_left_out !== e.left) report_mismatch("left_out", m_left_out, e.left);
                if (m_right_out !== e.right) report_mismatch("right_out", m_right_out, e.right);
                if (m_fade_active !== e.active)
                    report_mismatch("fade_active", 16'(m_fade_active), 16'(e.active));
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int rx_stall;
        rx_stall = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_stall = RX_HOLD_CYCLES;
            end
            if (rx_stall > 0) begin
                m_ready <= 1'b0;
                rx_stall--;
            end else begin
                m_ready <= 1'b1;
                rx_stall = pick_gap(rx_steady);
            end
        end
    end

    task automatic send_frame(pcmfi_pkg::op_t op, logic [pcmfi_pkg::SAMPLE_W-1:0] l,
                              logic [pcmfi_pkg::SAMPLE_W-1:0] r);
        int gap;
        s_valid    <= 1'b1;
        s_op       <= op;
        s_left_in  <= l;
        s_right_in <= r;
        do @(negedge aclk); while (!s_ready);
        predict_faded_frame(op, l, r);
        @(posedge aclk);
        gap = pick_gap(tx_steady);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // leaves cfg_valid high so back-to-back writes need one assignment per edge
    task automatic write_reg(pcmfi_pkg::cfg_reg_t idx, logic [pcmfi_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge aclk); while (!cfg_ready);
        case (idx)
            pcmfi_pkg::REG_SAMPLE_16BIT: shadow_cfg.sample_16bit = data[0];
            pcmfi_pkg::REG_STEREO:       shadow_cfg.stereo       = data[0];
            pcmfi_pkg::REG_FADE_LENGTH:
                shadow_cfg.fade_length = data[pcmfi_pkg::FRAMES_W-1:0];
            pcmfi_pkg::REG_FADE_STEP:
                shadow_cfg.fade_step   = data[pcmfi_pkg::STEP_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_config(bit is16, bit st, int len, int step);
        wait_drained();
        write_reg(pcmfi_pkg::REG_SAMPLE_16BIT, pcmfi_pkg::CFG_DATA_W'(is16));
        write_reg(pcmfi_pkg::REG_STEREO, pcmfi_pkg::CFG_DATA_W'(st));
        write_reg(pcmfi_pkg::REG_FADE_LENGTH, pcmfi_pkg::CFG_DATA_W'(len));
        write_reg(pcmfi_pkg::REG_FADE_STEP, pcmfi_pkg::CFG_DATA_W'(step));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [pcmfi_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 15))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            4: return 16'h00ff;
            5: return 16'h0080;
            6: return pcmfi_pkg::SAMPLE_W'($urandom_range(0, 255));
            default: return pcmfi_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return ($urandom_range(0, 1) == 0) ? 65535 : $urandom_range(256, 65535);
        return $urandom_range(1, 80);
    endfunction

    function automatic int pick_step();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r <= 3) return $urandom_range(1, 4096);
        if (r <= 7) return $urandom_range(512, 32768);
        if (r == 8) return $urandom_range(32769, 131071);
        return ($urandom_range(0, 1) == 0) ? 65536 : 131071;
    endfunction

    task automatic send_random_frame();
        pcmfi_pkg::op_t op;
        op = ($urandom_range(0, 39) == 0) ? pcmfi_pkg::OP_RESTART : pcmfi_pkg::OP_FRAME;
        send_frame(op, rand_sample(), rand_sample());
    endtask

    // reset defaults: no fade, plain frames pass through untouched and a restart gives zeros
    task automatic test_passthrough_after_reset();
        send_frame(pcmfi_pkg::OP_FRAME, 16'h8000, 16'h7fff);
        send_frame(pcmfi_pkg::OP_FRAME, 16'h7fff, 16'h8000);
        send_frame(pcmfi_pkg::OP_FRAME, 16'hffff, 16'h0000);
        send_frame(pcmfi_pkg::OP_RESTART, 16'h5555, 16'haaaa);
        send_frame(pcmfi_pkg::OP_FRAME, 16'h1234, 16'ha5a5);
    endtask

    // quarter steps: fade ends when the gain reaches unity
    task automatic test_fade_16bit_stereo();
        load_config(1'b1, 1'b1, 4, 16384);
        send_frame(pcmfi_pkg::OP_RESTART, 16'hffff, 16'hffff);
        send_frame(pcmfi_pkg::OP_FRAME, 16'h7fff, 16'h8000);
        send_frame(pcmfi_pkg::OP_FRAME, 16'h8000, 16'h7fff);
        send_frame(pcmfi_pkg::OP_FRAME, 16'hffff, 16'h0001);
        send_frame(pcmfi_pkg::OP_FRAME, 16'h4000, 16'hc000);
        send_frame(pcmfi_pkg::OP_FRAME, 16'h7fff, 16'h8000);
    endtask

    // bits above the byte are dropped while fading but kept in passthrough
    task automatic test_fade_8bit_stereo();
        load_config(1'b0, 1'b1, 3, 21845);
        send_frame(pcmfi_pkg::OP_RESTART, 16'h0000, 16'h0000);
        send_frame(pcmfi_pkg::OP_FRAME, 16'h00ff, 16'h0000);
        send_frame(pcmfi_pkg::OP_FRAME, 16'hff80, 16'h007f);
        send_frame(pcmfi_pkg::OP_FRAME, 16'h0001, 16'h00fe);
        send_frame(pcmfi_pkg::OP_FRAME, 16'hab12, 16'h34cd);
    endtask

    task automatic test_mono_and_step_extremes();
        // zero step: only the frame count ends the fade
        load_config(1'b1, 1'b0, 2, 0);
        send_frame(pcmfi_pkg::OP_RESTART, 16'h8000, 16'h8000);
        send_frame(pcmfi_pkg::OP_FRAME, 16'h8000, 16'h8001);
        send_frame(pcmfi_pkg::OP_FRAME, 16'h7fff, 16'hffff);
        send_frame(pcmfi_pkg::OP_FRAME, 16'h1111, 16'h2222);
        // step beyond unity ends after one frame
        load_config(1'b0, 1'b0, 2, 131071);
        send_frame(pcmfi_pkg::OP_RESTART, 16'h0000, 16'h0000);
        send_frame(pcmfi_pkg::OP_FRAME, 16'h0000, 16'hfe01);
        send_frame(pcmfi_pkg::OP_FRAME, 16'h00ff, 16'h00ff);
        load_config(1'b1, 1'b1, 3, 65536);
        send_frame(pcmfi_pkg::OP_RESTART, 16'h0000, 16'h0000);
        send_frame(pcmfi_pkg::OP_FRAME, 16'h7fff, 16'h8000);
        send_frame(pcmfi_pkg::OP_FRAME, 16'h7fff, 16'h8000);
    endtask

    // result side holds off while the sender keeps offering beats
    task automatic test_backpressure();
        load_config(1'b1, 1'b1, 30, 2500);
        tx_steady   = 1'b1;
        rx_hold_req = 1'b1;
        send_frame(pcmfi_pkg::OP_RESTART, 16'h0000, 16'h0000);
        repeat (23) send_random_frame();
        tx_steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_steady_stream();
        load_config(1'b0, 1'b1, 25, 3000);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        send_frame(pcmfi_pkg::OP_RESTART, 16'h0000, 16'h0000);
        repeat (39) send_random_frame();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // each phase loads a new setting and sends a restart, then random frames
    task automatic test_random_phases();
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: load_config(1'b1, 1'b1, 65535, 1);
                1: load_config(1'b0, 1'b0, 0, 131071);
                2: load_config(1'b0, 1'b1, 65535, 0);
                default: load_config($urandom_range(0, 1), $urandom_range(0, 1),
                                     pick_length(), pick_step());
            endcase
            send_frame(pcmfi_pkg::OP_RESTART, rand_sample(), rand_sample());
            repeat (89) send_random_frame();
        end
    endtask

    initial begin
        shadow_cfg.sample_16bit = 1'b1;
        shadow_cfg.stereo       = 1'b1;
        shadow_cfg.fade_length  = '0;
        shadow_cfg.fade_step    = pcmfi_pkg::STEP_W'(1);
        ramp_gain   = '0;
        ramp_frames = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_passthrough_after_reset();
        test_fade_16bit_stereo();
        test_fade_8bit_stereo();
        test_mono_and_step_extremes();
        test_backpressure();
        test_steady_stream();
        test_random_phases();

        s_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
